// ----- sv/clbp_pkg.sv -----
`default_nettype none
package clbp_pkg;

	localparam int MAX_COLUMNS = 256;
	localparam int MAX_CELLS   = 65536;
	localparam int WIN_DEPTH   = 2 * MAX_COLUMNS + 3;
	localparam int SLOT_W      = $clog2(WIN_DEPTH);
	localparam int CNT_W       = 17;
	localparam int COLS_W      = 9;
	localparam int NB          = 9;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);
	localparam int ADDR_W      = 3;
	localparam int COLS_RESET  = 16;

	localparam logic       OP_PUSH     = 1'b0;
	localparam logic       OP_DRAIN    = 1'b1;
	localparam logic [0:0] REG_COLUMNS = 1'b0;

	typedef logic [NB-1:0][7:0] gray_vec_t;

	typedef struct packed {
		logic [15:0]   cell_index;
		logic          last;
		logic [NB-1:0] mask;
		gray_vec_t     gray;
	} code_job_t;

	// neighbour k in visiting order: dc outer, dr inner, k = 3*(dc+1) + (dr+1)
	function automatic logic signed [10:0] nb_offset(input logic [3:0] k,
		input logic [COLS_W-1:0] cols);
		logic signed [10:0] c;
		logic signed [10:0] d;
		c = {2'b00, cols};
		case (k)
			4'd0:    d = -c - 11'sd1;
			4'd1:    d = -11'sd1;
			4'd2:    d = c - 11'sd1;
			4'd3:    d = -c;
			4'd5:    d = c;
			4'd6:    d = 11'sd1 - c;
			4'd7:    d = 11'sd1;
			4'd8:    d = c + 11'sd1;
			default: d = 11'sd0;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

// ----- sv/clbp_if.sv -----
`default_nettype none
interface clbp_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] gray_level;
	modport source (output valid, op, gray_level, input ready);
	modport sink (input valid, op, gray_level, output ready);
endinterface

interface clbp_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] cell_index;
	logic [8:0]  pattern_code;
	logic [3:0]  bit_count;
	logic        last_of_frame;
	modport source (output valid, cell_index, pattern_code, bit_count, last_of_frame,
		input ready);
	modport sink (input valid, cell_index, pattern_code, bit_count, last_of_frame,
		output ready);
endinterface
`default_nettype wire

// ----- sv/cell_local_binary_pattern_unit.sv -----
`default_nettype none
// 3x3 local binary pattern over a raster of cell gray levels.
// Throughput: one beat per cycle on the input, push or drain, while queue credits are free,
// set by the nine single-read window RAM copies that fetch all neighbours of a code at once.
// Path: a code passes the fetch-address register, the window RAM read register, the job queue and the output register.
// Reset (arst_n low, async): counters, queue and output valid clear, columns = 16.
// Window RAMs have no reset and need no clearing pass.
module cell_local_binary_pattern_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	clbp_in_if.sink                            in_ch,
	clbp_out_if.source                         out_ch,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [clbp_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready
);
	logic [clbp_pkg::COLS_W-1:0] columns_q;
	logic                        job_push, job_valid, pop;
	clbp_pkg::code_job_t         job_in, job_out;
	logic [clbp_pkg::QCNT_W-1:0] q_count;
	logic                        reg_hit;

	// register index is the word address
	assign reg_hit = paddr[2] == clbp_pkg::REG_COLUMNS;
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? 32'(columns_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= clbp_pkg::COLS_W'(clbp_pkg::COLS_RESET);
		end else if (psel && penable && pwrite && reg_hit) begin
			columns_q <= pwdata[clbp_pkg::COLS_W-1:0];
		end
	end

	// front: counters, window writes, neighbour fetch (two stages)
	clbp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.columns  (columns_q),
		.pop      (pop),
		.job_push (job_push),
		.job      (job_in)
	);

	// fetched jobs wait here while the output stalls; front holds credits
	clbp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.din       (job_in),
		.pop       (pop),
		.not_empty (job_valid),
		.dout      (job_out),
		.count     (q_count)
	);

	// back: compare against the centre, pack bits, output register
	clbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job_out),
		.pop       (pop),
		.out_ch    (out_ch)
	);

	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= clbp_pkg::QCNT_W'(clbp_pkg::QDEPTH))
		else $error("queue count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_count != '0)
		else $error("pop from empty queue");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_push && q_count == clbp_pkg::QCNT_W'(clbp_pkg::QDEPTH) |-> pop)
		else $error("queue overflow");
endmodule
`default_nettype wire

// ----- sv/clbp_ram.sv -----
`default_nettype none
module clbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 515
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// read-first: a read at the write address returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- sv/clbp_front.sv -----
`default_nettype none
module clbp_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	clbp_in_if.sink                            in_ch,
	input  wire logic [clbp_pkg::COLS_W-1:0]   columns,
	input  wire logic                          pop,
	output logic                               job_push,
	output clbp_pkg::code_job_t                job
);
	localparam int SW  = clbp_pkg::SLOT_W;
	localparam int CW  = clbp_pkg::CNT_W;
	localparam int NB  = clbp_pkg::NB;
	localparam int QCW = clbp_pkg::QCNT_W;

	logic [CW-1:0] received_q, emitted_q;
	logic [SW-1:0] rx_slot_q, e_slot_q;
	logic [clbp_pkg::QCNT_W-1:0] credit_q;

	logic [clbp_pkg::COLS_W-1:0] cols;
	logic accept, is_push, full, push_ok, emit, last;
	logic [CW-1:0] rx_next, limit;

	logic [NB-1:0][SW-1:0] slot_c;
	logic [NB-1:0]         mask_c;

	logic                  v_s1, v_s2;
	logic [NB-1:0][SW-1:0] slot_s1;
	logic [NB-1:0]         mask_s1, mask_s2;
	logic [15:0]           idx_s1, idx_s2;
	logic                  last_s1, last_s2;
	clbp_pkg::gray_vec_t   rdata;

	always_comb begin
		if (columns == '0) begin
			cols = clbp_pkg::COLS_W'(1);
		end else if (columns > clbp_pkg::COLS_W'(clbp_pkg::MAX_COLUMNS)) begin
			cols = clbp_pkg::COLS_W'(clbp_pkg::MAX_COLUMNS);
		end else begin
			cols = columns;
		end
	end

	// queue slots are reserved at accept time
	assign in_ch.ready = credit_q < clbp_pkg::QCNT_W'(clbp_pkg::QDEPTH);
	assign accept  = in_ch.valid && in_ch.ready;
	assign is_push = in_ch.op == clbp_pkg::OP_PUSH;
	assign full    = received_q == CW'(clbp_pkg::MAX_CELLS);
	assign push_ok = accept && is_push && !full;
	assign rx_next = received_q + CW'(1);
	assign limit   = is_push ? rx_next : received_q;
	assign last    = !is_push && (emitted_q + CW'(1) == received_q);

	always_comb begin
		if (is_push) begin
			emit = push_ok && ({1'b0, rx_next} >=
				{1'b0, emitted_q} + (CW+1)'(cols) + (CW+1)'(2));
		end else begin
			emit = accept && (emitted_q < received_q);
		end
	end

	for (genvar k = 0; k < NB; k++) begin : g_lane
		logic signed [10:0] off;
		logic signed [CW+1:0] pos;
		logic signed [SW+1:0] raw;
		assign off = clbp_pkg::nb_offset(4'(k), cols);
		assign pos = $signed({2'b00, emitted_q}) + {{(CW-9){off[10]}}, off};
		assign raw = $signed({2'b00, e_slot_q}) + {{(SW-9){off[10]}}, off};
		assign mask_c[k] = !pos[CW+1] && (pos[CW:0] < {1'b0, limit});
		always_comb begin
			if (raw[SW+1]) begin
				slot_c[k] = SW'(raw + (SW+2)'(clbp_pkg::WIN_DEPTH));
			end else if (raw >= (SW+2)'(clbp_pkg::WIN_DEPTH)) begin
				slot_c[k] = SW'(raw - (SW+2)'(clbp_pkg::WIN_DEPTH));
			end else begin
				slot_c[k] = SW'(raw);
			end
		end
		clbp_ram #(.WIDTH(8), .DEPTH(clbp_pkg::WIN_DEPTH)) u_ram (
			.clk   (clk),
			.we    (push_ok),
			.waddr (rx_slot_q),
			.wdata (in_ch.gray_level),
			.raddr (slot_s1[k]),
			.rdata (rdata[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			received_q <= '0;
			emitted_q  <= '0;
			rx_slot_q  <= '0;
			e_slot_q   <= '0;
			credit_q   <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
		end else begin
			v_s1     <= emit;
			v_s2     <= v_s1;
			credit_q <= credit_q + QCW'(emit) - QCW'(pop);
			if (emit && last) begin
				received_q <= '0;
				emitted_q  <= '0;
				rx_slot_q  <= '0;
				e_slot_q   <= '0;
			end else begin
				if (push_ok) begin
					received_q <= rx_next;
					rx_slot_q  <= (rx_slot_q == SW'(clbp_pkg::WIN_DEPTH - 1)) ?
						'0 : rx_slot_q + SW'(1);
				end
				if (emit) begin
					emitted_q <= emitted_q + CW'(1);
					e_slot_q  <= (e_slot_q == SW'(clbp_pkg::WIN_DEPTH - 1)) ?
						'0 : e_slot_q + SW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= slot_c;
		mask_s1 <= mask_c;
		idx_s1  <= emitted_q[15:0];
		last_s1 <= last;
		mask_s2 <= mask_s1;
		idx_s2  <= idx_s1;
		last_s2 <= last_s1;
	end

	assign job_push        = v_s2;
	assign job.cell_index  = idx_s2;
	assign job.last        = last_s2;
	assign job.mask        = mask_s2;
	assign job.gray        = rdata;
endmodule
`default_nettype wire

// ----- sv/clbp_queue.sv -----
`default_nettype none
module clbp_queue (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire clbp_pkg::code_job_t           din,
	input  wire logic                          pop,
	output logic                               not_empty,
	output clbp_pkg::code_job_t                dout,
	output logic [clbp_pkg::QCNT_W-1:0]        count
);
	localparam int PW = clbp_pkg::QPTR_W;

	clbp_pkg::code_job_t   entry_q [clbp_pkg::QDEPTH];
	logic [PW-1:0]         wr_q, rd_q;
	logic [clbp_pkg::QCNT_W-1:0] cnt_q;

	assign not_empty = cnt_q != '0;
	assign dout      = entry_q[rd_q];
	assign count     = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PW'(1);
			end
			cnt_q <= cnt_q + clbp_pkg::QCNT_W'(push) - clbp_pkg::QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= din;
		end
	end
endmodule
`default_nettype wire

// ----- sv/clbp_back.sv -----
`default_nettype none
module clbp_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                job_valid,
	input  wire clbp_pkg::code_job_t job,
	output logic                     pop,
	clbp_out_if.source               out_ch
);
	logic        valid_q;
	logic [8:0]  code;
	logic [3:0]  count;
	logic [7:0]  centre;

	assign pop = job_valid && (!valid_q || out_ch.ready);
	assign centre = job.gray[4];

	// pack in visiting order, first valid neighbour ends up most significant
	always_comb begin
		code  = '0;
		count = '0;
		for (int k = 0; k < clbp_pkg::NB; k++) begin
			if (job.mask[k]) begin
				code  = {code[7:0], job.gray[k] >= centre};
				count = count + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_ch.cell_index    <= job.cell_index;
			out_ch.pattern_code  <= code;
			out_ch.bit_count     <= count;
			out_ch.last_of_frame <= job.last;
		end
	end

	assign out_ch.valid = valid_q;
endmodule
`default_nettype wire
